/* hw/rtl/kra_pkg.sv */
// ----------------------------------------------------------------------------
// kra_pkg
// Shared types, constants and the keycode-to-character map for the keyboard
// report to ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package kra_pkg;

  localparam int unsigned KeyW        = 8;
  localparam int unsigned CharW       = 7;
  localparam int unsigned SlotW       = 3;
  localparam int unsigned MaxSlots    = 6;
  localparam int unsigned KeySlotsDef = 6;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned InDataW  = 56;  // modifier + six key slots
  localparam int unsigned OutDataW = 16;  // char + slot + zero fill

  localparam logic [KeyW-1:0] ShiftMask = 8'h22;  // left shift | right shift

  localparam logic [KeyW-1:0] KeyLetterFirst = 8'h04;
  localparam logic [KeyW-1:0] KeyLetterLast  = 8'h1D;
  localparam logic [KeyW-1:0] KeyEnter       = 8'h28;
  localparam logic [KeyW-1:0] KeyBackspace   = 8'h2A;
  localparam logic [KeyW-1:0] KeySpace       = 8'h2C;
  localparam logic [KeyW-1:0] KeyRightArrow  = 8'h4F;
  localparam logic [KeyW-1:0] KeyLeftArrow   = 8'h50;

  localparam logic [CharW-1:0] CharLowerA  = 7'h61;
  localparam logic [CharW-1:0] CaseOffset  = 7'd32;
  localparam logic [CharW-1:0] CharLf      = 7'd10;
  localparam logic [CharW-1:0] CharBs      = 7'd8;
  localparam logic [CharW-1:0] CharLeft    = 7'd2;
  localparam logic [CharW-1:0] CharRight   = 7'd3;
  localparam logic [CharW-1:0] CharNone    = 7'd0;

  // One decoded report: which slots carry a newly pressed key, and their chars.
  typedef struct packed {
    logic [MaxSlots-1:0]            new_mask;
    logic [MaxSlots-1:0][CharW-1:0] chars;
  } report_t;

  function automatic logic [CharW-1:0] map_key(input logic [KeyW-1:0] key,
                                               input logic            shift);
    logic [CharW-1:0] plain;
    logic [CharW-1:0] shifted;
    logic [CharW-1:0] result;
    plain   = CharNone;
    shifted = CharNone;
    case (key)
      8'h1E: begin plain = 7'h31; shifted = 7'h21; end  // 1 !
      8'h1F: begin plain = 7'h32; shifted = 7'h40; end  // 2 @
      8'h20: begin plain = 7'h33; shifted = 7'h23; end  // 3 #
      8'h21: begin plain = 7'h34; shifted = 7'h24; end  // 4 $
      8'h22: begin plain = 7'h35; shifted = 7'h25; end  // 5 %
      8'h23: begin plain = 7'h36; shifted = 7'h5E; end  // 6 ^
      8'h24: begin plain = 7'h37; shifted = 7'h26; end  // 7 &
      8'h25: begin plain = 7'h38; shifted = 7'h2A; end  // 8 *
      8'h26: begin plain = 7'h39; shifted = 7'h28; end  // 9 (
      8'h27: begin plain = 7'h30; shifted = 7'h29; end  // 0 )
      8'h2D: begin plain = 7'h2D; shifted = 7'h5F; end  // - _
      8'h2E: begin plain = 7'h3D; shifted = 7'h2B; end  // = +
      8'h2F: begin plain = 7'h5B; shifted = 7'h7B; end  // [ {
      8'h30: begin plain = 7'h5D; shifted = 7'h7D; end  // ] }
      8'h31: begin plain = 7'h5C; shifted = 7'h7C; end  // \ |
      8'h33: begin plain = 7'h3B; shifted = 7'h3A; end  // ; :
      8'h34: begin plain = 7'h27; shifted = 7'h22; end  // ' "
      8'h35: begin plain = 7'h60; shifted = 7'h7E; end  // ` ~
      8'h36: begin plain = 7'h2C; shifted = 7'h3C; end  // , <
      8'h37: begin plain = 7'h2E; shifted = 7'h3E; end  // . >
      8'h38: begin plain = 7'h2F; shifted = 7'h3F; end  // / ?
      KeyEnter:      plain = CharLf;
      KeyBackspace:  plain = CharBs;
      KeySpace:      plain = 7'h20;
      KeyRightArrow: plain = CharRight;
      KeyLeftArrow:  plain = CharLeft;
      default:       plain = CharNone;
    endcase
    if (key >= KeyLetterFirst && key <= KeyLetterLast) begin
      plain   = CharW'(key - KeyLetterFirst) + CharLowerA;
      shifted = plain - CaseOffset;
    end
    result = (shift && shifted != CharNone) ? shifted : plain;
    return result;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/keyboard_report_to_ascii.sv */
// ----------------------------------------------------------------------------
// keyboard_report_to_ascii
// Turns keyboard boot reports into a stream of characters for new key presses.
// ----------------------------------------------------------------------------
// Each accepted report is compared with the previous one; every nonzero slot
// whose keycode was absent from the previous report yields one character,
// lowest slot first, with tlast on the final character of that report. The
// characters of a report move into the output register one per cycle while
// the sink is ready; a report that yields none sends nothing. The next report
// is accepted in the cycle in which the last character of the one before
// moves into the output register, so reports and characters flow without
// gaps. Reset clears the stored previous report.
`default_nettype none

module keyboard_report_to_ascii #(
  parameter int unsigned KEY_SLOTS = kra_pkg::KeySlotsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] modifier_bits, [15:8] pressed_key_0 ... [55:48] pressed_key_5
  input  wire logic [kra_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [6:0] ascii_char, [9:7] source_slot, [15:10] zero
  output logic [kra_pkg::OutDataW-1:0]        m_axis_tdata,
  output logic                                m_axis_tlast
);
  import kra_pkg::*;

  logic [KEY_SLOTS-1:0][KeyW-1:0] prev_q;
  report_t                        dec;
  logic                           accept;
  logic [CharW-1:0]               out_char;
  logic [SlotW-1:0]               out_slot;

  assign accept = s_axis_tvalid && s_axis_tready;

  kra_decode #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_decode (
    .rpt_i (s_axis_tdata),
    .prev_i(prev_q),
    .dec_o (dec)
  );

  kra_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .dec_i      (dec),
    .load_ok_o  (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_char_o (out_char),
    .out_slot_o (out_slot),
    .out_last_o (m_axis_tlast)
  );

  // Store the keys of each accepted report for the next comparison.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (accept) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_q[i] <= s_axis_tdata[KeyW*(i+1) +: KeyW];
      end
    end
  end

  assign m_axis_tdata = {(OutDataW - CharW - SlotW)'(0), out_slot, out_char};

endmodule

`default_nettype wire

/* hw/rtl/kra_decode.sv */
// ----------------------------------------------------------------------------
// kra_decode
// Finds the newly pressed keys of a report against the previous report and
// maps every slot to its character.
// ----------------------------------------------------------------------------
`default_nettype none

module kra_decode #(
  parameter int unsigned KEY_SLOTS = kra_pkg::KeySlotsDef
) (
  input  wire logic [kra_pkg::InDataW-1:0]            rpt_i,
  input  wire logic [KEY_SLOTS-1:0][kra_pkg::KeyW-1:0] prev_i,
  output kra_pkg::report_t                             dec_o
);
  import kra_pkg::*;

  logic                        shift;
  logic [MaxSlots-1:0]         seen;
  logic [MaxSlots-1:0][KeyW-1:0] keys;

  assign shift = |(rpt_i[KeyW-1:0] & ShiftMask);

  always_comb begin
    for (int i = 0; i < MaxSlots; i++) begin
      keys[i] = rpt_i[KeyW*(i+1) +: KeyW];
      seen[i] = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (prev_i[j] == keys[i]) begin
          seen[i] = 1'b1;
        end
      end
      if (i < KEY_SLOTS) begin
        dec_o.new_mask[i] = (keys[i] != '0) && !seen[i];
        dec_o.chars[i]    = map_key(keys[i], shift);
      end else begin
        dec_o.new_mask[i] = 1'b0;
        dec_o.chars[i]    = CharNone;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/kra_emit.sv */
// ----------------------------------------------------------------------------
// kra_emit
// Holds one decoded report and sends its characters out, lowest slot first,
// one per cycle through the output register while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module kra_emit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire kra_pkg::report_t             dec_i,
  output logic                              load_ok_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [kra_pkg::CharW-1:0]         out_char_o,
  output logic [kra_pkg::SlotW-1:0]         out_slot_o,
  output logic                              out_last_o
);
  import kra_pkg::*;

  logic [MaxSlots-1:0]            pend_mask_q, pend_mask_d;
  logic [MaxSlots-1:0][CharW-1:0] pend_char_q;
  logic                           out_valid_q, out_valid_d;
  logic [CharW-1:0]               out_char_q;
  logic [SlotW-1:0]               out_slot_q;
  logic                           out_last_q;

  logic                out_free;
  logic                take;
  logic [SlotW-1:0]    sel_slot;
  logic [MaxSlots-1:0] sel_bit;
  logic [MaxSlots-1:0] rest_mask;

  // Lowest pending slot goes first.
  always_comb begin
    sel_slot = '0;
    sel_bit  = '0;
    for (int i = MaxSlots - 1; i >= 0; i--) begin
      if (pend_mask_q[i]) begin
        sel_slot = SlotW'(i);
        sel_bit  = MaxSlots'(1) << i;
      end
    end
  end

  assign rest_mask = pend_mask_q & ~sel_bit;
  assign out_free  = !out_valid_q || out_ready_i;
  assign take      = out_free && (pend_mask_q != '0);
  assign load_ok_o = (pend_mask_q == '0) || (take && rest_mask == '0);

  always_comb begin
    pend_mask_d = pend_mask_q;
    if (load_i) begin
      pend_mask_d = dec_i.new_mask;
    end else if (take) begin
      pend_mask_d = rest_mask;
    end
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_mask_q <= pend_mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pend_char_q <= dec_i.chars;
    end
    if (take) begin
      out_char_q <= pend_char_q[sel_slot];
      out_slot_q <= sel_slot;
      out_last_q <= (rest_mask == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_slot_o  = out_slot_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

/* hw/rtl/kra_checker.sv */
// ----------------------------------------------------------------------------
// kra_checker
// Port-level checks on the character stream of the report converter.
// ----------------------------------------------------------------------------
`default_nettype none

module kra_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [55:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  logic m_xfer;
  assign m_xfer = m_axis_tvalid && m_axis_tready;

  // A stalled report holds at the input.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input changed while stalled");

  // A stalled character holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // Characters of one report follow each other without a gap.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_xfer && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a report");

  // Within a report, slots strictly increase.
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_xfer && !m_axis_tlast |=> m_axis_tdata[9:7] > $past(m_axis_tdata[9:7]))
    else $error("slot order broken");

  // Slot index stays within the report and the fill bits are zero.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[9:7] < 3'd6 && m_axis_tdata[15:10] == 6'd0)
    else $error("bad slot or fill bits");

endmodule

bind keyboard_report_to_ascii kra_checker u_kra_checker (.*);

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the keyboard report to ASCII converter: directed and
// random key reports go in, the emitted characters are checked in order
// against a local model of the key map and of the previous-report filter.
// ----------------------------------------------------------------------------

module testbench;
  import kra_pkg::*;

  localparam int WatchdogCycles = 2000;
  localparam int SinkHoldCycles = 300;
  localparam int HoldAfterReports = 40;
  localparam int RandomReports = 130;

  typedef struct packed {
    logic [KeyW-1:0]                 modifier;
    logic [MaxSlots-1:0][KeyW-1:0]   keys;
    logic                            drain_first;
  } key_report_t;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic [SlotW-1:0] slot;
    logic             last;
  } typed_char_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;

  key_report_t                    pending_reports[$];
  typed_char_t                    typed_chars[$];
  logic [MaxSlots-1:0][KeyW-1:0]  last_keys = '0;

  key_report_t cur_report;
  bit  offering = 1'b0;
  bit  report_taken = 1'b0;
  bit  char_taken = 1'b0;
  bit  hold_done = 1'b0;
  int  send_gap = 0;
  int  sink_gap = 0;
  int  hold_left = 0;
  int  cycle_count = 0;
  int  quiet_cycles = 0;
  int  reports_taken = 0;
  int  chars_taken = 0;
  int  mismatches = 0;
  int  directed_count = 0;

  keyboard_report_to_ascii dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic logic [CharW-1:0] char_for_key(input logic [KeyW-1:0] key,
                                                    input logic            shifted);
    logic [7:0] lower;
    logic [7:0] upper;
    lower = 8'd0;
    upper = 8'd0;
    case (key)
      8'h1E: begin lower = "1"; upper = "!"; end
      8'h1F: begin lower = "2"; upper = "@"; end
      8'h20: begin lower = "3"; upper = "#"; end
      8'h21: begin lower = "4"; upper = "$"; end
      8'h22: begin lower = "5"; upper = "%"; end
      8'h23: begin lower = "6"; upper = "^"; end
      8'h24: begin lower = "7"; upper = "&"; end
      8'h25: begin lower = "8"; upper = "*"; end
      8'h26: begin lower = "9"; upper = "("; end
      8'h27: begin lower = "0"; upper = ")"; end
      8'h2D: begin lower = "-"; upper = "_"; end
      8'h2E: begin lower = "="; upper = "+"; end
      8'h2F: begin lower = "["; upper = "{"; end
      8'h30: begin lower = "]"; upper = "}"; end
      8'h31: begin lower = 8'h5C; upper = "|"; end  // backslash
      8'h33: begin lower = ";"; upper = ":"; end
      8'h34: begin lower = "'"; upper = 8'h22; end  // double quote
      8'h35: begin lower = 8'h60; upper = "~"; end  // backtick
      8'h36: begin lower = ","; upper = "<"; end
      8'h37: begin lower = "."; upper = ">"; end
      8'h38: begin lower = "/"; upper = "?"; end
      KeyEnter:      lower = 8'd10;
      KeyBackspace:  lower = 8'd8;
      KeySpace:      lower = " ";
      KeyRightArrow: lower = 8'd3;
      KeyLeftArrow:  lower = 8'd2;
      default:       lower = 8'd0;
    endcase
    if (key >= KeyLetterFirst && key <= KeyLetterLast) begin
      lower = "a" + 8'(key - KeyLetterFirst);
      upper = lower - 8'd32;
    end
    // keys without a shifted glyph fall back to the plain one
    return (shifted && upper != 8'd0) ? upper[CharW-1:0] : lower[CharW-1:0];
  endfunction

  task automatic predict_chars(input logic [InDataW-1:0] data);
    logic [MaxSlots-1:0][KeyW-1:0] keys;
    logic        shifted;
    bit          seen;
    int          first_new;
    typed_char_t one;
    keys      = data[InDataW-1:KeyW];
    shifted   = (data[KeyW-1:0] & ShiftMask) != '0;
    first_new = typed_chars.size();
    for (int i = 0; i < MaxSlots; i++) begin
      if (keys[i] != '0) begin
        seen = 1'b0;
        for (int j = 0; j < MaxSlots; j++) begin
          if (last_keys[j] == keys[i]) seen = 1'b1;
        end
        if (!seen) begin
          one.ch   = char_for_key(keys[i], shifted);
          one.slot = SlotW'(i);
          one.last = 1'b0;
          typed_chars.push_back(one);
        end
      end
    end
    if (typed_chars.size() > first_new) typed_chars[typed_chars.size() - 1].last = 1'b1;
    last_keys = keys;
  endtask

  task automatic add_report(input logic [KeyW-1:0] modifier,
                            input logic [KeyW-1:0] k0, input logic [KeyW-1:0] k1,
                            input logic [KeyW-1:0] k2, input logic [KeyW-1:0] k3,
                            input logic [KeyW-1:0] k4, input logic [KeyW-1:0] k5,
                            input logic            drain_first);
    key_report_t r;
    r.modifier    = modifier;
    r.keys        = {k5, k4, k3, k2, k1, k0};
    r.drain_first = drain_first;
    pending_reports.push_back(r);
  endtask

  function automatic int draw_wait();
    // one window in four, chosen by cycle-count bits 8:7, runs with no idling on either side
    if (cycle_count[8:7] == 2'd0) return 0;
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [KeyW-1:0] pick_typing_key();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? KeyLeftArrow : KeyRightArrow;
    return KeyW'($urandom_range(KeyLetterFirst, 8'h38));
  endfunction

  // Sender: hold each report until its transfer, then wait a drawn gap.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (report_taken) begin
        report_taken = 1'b0;
        offering     = 1'b0;
        send_gap     = draw_wait();
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reports.size() > 0 &&
                     !(pending_reports[0].drain_first && typed_chars.size() != 0)) begin
          cur_report = pending_reports.pop_front();
          offering   = 1'b1;
        end
      end
      s_axis_tvalid <= offering;
      if (offering) s_axis_tdata <= {cur_report.keys, cur_report.modifier};
    end
  end

  // Receiver: stall a drawn number of cycles after each character, and once
  // hold off long enough for the converter to back up into its input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (char_taken) begin
        char_taken = 1'b0;
        sink_gap   = draw_wait();
      end
      if (!hold_done && reports_taken >= HoldAfterReports) begin
        hold_done = 1'b1;
        hold_left = SinkHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      typed_char_t want;
      cycle_count++;
      quiet_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        char_taken   = 1'b1;
        chars_taken++;
        if (typed_chars.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected character: expected none, got char %0d slot %0d last %0b",
                   $time, m_axis_tdata[CharW-1:0], m_axis_tdata[CharW+SlotW-1:CharW],
                   m_axis_tlast);
        end else begin
          want = typed_chars.pop_front();
          if (m_axis_tdata[CharW-1:0] !== want.ch) begin
            mismatches++;
            $display("%0t: ascii_char mismatch: expected %0d, got %0d",
                     $time, want.ch, m_axis_tdata[CharW-1:0]);
          end
          if (m_axis_tdata[CharW+SlotW-1:CharW] !== want.slot) begin
            mismatches++;
            $display("%0t: source_slot mismatch: expected %0d, got %0d",
                     $time, want.slot, m_axis_tdata[CharW+SlotW-1:CharW]);
          end
          if (m_axis_tlast !== want.last) begin
            mismatches++;
            $display("%0t: last_of_report mismatch: expected %0b, got %0b",
                     $time, want.last, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        quiet_cycles = 0;
        report_taken = 1'b1;
        reports_taken++;
        predict_chars(s_axis_tdata);
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    wait (quiet_cycles >= WatchdogCycles);
    $display("%0t: no transfer for %0d cycles, giving up", $time, WatchdogCycles);
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [MaxSlots-1:0][KeyW-1:0] held;
    logic [KeyW-1:0]               modifier;
    int                            pick;

    // directed: map extremes, both shift bits, repeats, unmapped codes
    add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_report(8'h00, 8'h04, 8'h1D, 8'h1E, 8'h27, KeyEnter, KeyBackspace, 1'b0);
    add_report(8'h02, 8'h1D, KeySpace, KeyRightArrow, KeyLeftArrow, 8'h2D, 8'h38, 1'b0);
    add_report(8'h20, 8'h05, 8'h1F, 8'h2F, 8'h30, 8'h31, 8'h33, 1'b0);
    add_report(8'hFF, 8'h34, 8'h35, 8'h36, 8'h37, 8'h00, 8'h0A, 1'b0);
    add_report(8'hDD, 8'h34, 8'h35, 8'h36, 8'h37, 8'hFF, 8'h01, 1'b0);
    add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_report(8'h00, 8'h0B, 8'h0B, 8'h0B, 8'h0B, 8'h0B, 8'h0B, 1'b0);
    add_report(8'h00, 8'h0B, 8'h0B, 8'h0B, 8'h0B, 8'h0B, 8'h0B, 1'b1);
    add_report(8'h02, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 1'b0);
    add_report(8'h22, 8'h26, 8'h27, 8'h2E, 8'h1E, 8'h32, 8'h39, 1'b0);
    add_report(8'h00, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h33, 1'b0);
    add_report(8'h00, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, KeySpace, 1'b0);
    add_report(8'h55, 8'h80, 8'h7F, 8'h40, 8'hE0, 8'hE7, 8'hFF, 1'b0);
    add_report(8'h80, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 1'b0);
    add_report(8'h00, 8'h00, 8'h24, 8'h00, 8'h25, 8'h00, 8'h26, 1'b0);
    add_report(8'h00, 8'h26, 8'h25, 8'h24, 8'h00, 8'h00, 8'h10, 1'b0);
    add_report(8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    directed_count = pending_reports.size();

    // random: mostly typing sessions that press, hold and release keys,
    // with some noise reports and empty reports mixed in
    held = '0;
    for (int n = 0; n < RandomReports; n++) begin
      pick     = $urandom_range(0, 9);
      modifier = KeyW'($urandom_range(0, 255));
      if (pick == 0) begin
        for (int i = 0; i < MaxSlots; i++) held[i] = KeyW'($urandom_range(0, 255));
      end else if (pick == 1) begin
        held = '0;
      end else begin
        for (int i = 0; i < MaxSlots; i++) begin
          case ($urandom_range(0, 3))
            0:       held[i] = '0;
            1:       ;  // keep the key held
            default: held[i] = pick_typing_key();
          endcase
        end
      end
      add_report(modifier, held[0], held[1], held[2], held[3], held[4], held[5],
                 n == 80);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_reports.size() == 0 && !offering && typed_chars.size() == 0);
    repeat (20) @(posedge clk_i);

    $display("covered %0d reports (%0d directed) yielding %0d characters,",
             reports_taken, directed_count, chars_taken);
    $display("with random stalls, a long sink hold and a full drain pause");
    if (mismatches == 0 && typed_chars.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* keyboard_report_to_ascii.f */
hw/rtl/kra_pkg.sv
hw/rtl/kra_decode.sv
hw/rtl/kra_emit.sv
hw/rtl/keyboard_report_to_ascii.sv
hw/rtl/kra_checker.sv
test/testbench.sv
